// File: rtl/core/sfd_pkg.sv
// Shared constants, types and register codes of the stereo feedback delay.
`default_nettype none
package sfd_pkg;

  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int DL_W        = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;

  localparam int SAMPLE_W    = 16;
  localparam int LP_W        = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 3'd4;

  localparam logic [15:0] DELAY_RST = 16'd12000;
  localparam logic [14:0] GAIN_RST  = 15'd13107;
  localparam logic [15:0] WET_RST   = 16'd16384;
  localparam logic [14:0] DAMP_RST  = 15'd17826;
  localparam logic [14:0] FB_LIMIT  = 15'd32440;
  localparam logic [15:0] WET_UNITY = 16'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  typedef struct packed {
    logic ch;
    logic step_a;
    logic step_b;
    logic step_c;
    logic step_d;
  } dp_ctrl_t;

  typedef struct packed {
    logic    rd_en;
    addr_t   rd_addr;
    logic    we;
    logic    wch;
    addr_t   waddr;
    sample_t wdata;
  } store_req_t;

endpackage
`default_nettype wire

// File: rtl/core/sfd_in_if.sv
// Input frame channel: valid, ready and the two dry samples.
`default_nettype none
interface sfd_in_if;
  import sfd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sfd_out_if.sv
// Result frame channel: valid, ready and the two mixed samples.
`default_nettype none
interface sfd_out_if;
  import sfd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sfd_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
`default_nettype none
interface sfd_cfg_if;
  import sfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/stereo_feedback_delay.sv
// Top level: configuration registers, channel sequencer and result register.
//
//   channel  dir  payload                          transfer
//   in_ch    in   left_sample, right_sample        valid & ready
//   out_ch   out  left_out, right_out              valid & ready
//   cfg_ch   in   index (3 bits), data (16 bits)   valid & ready, always ready
//
// A frame starts with the accept cycle, which issues the memory read, then four
// steps per channel (multiply, round/clamp, feedback multiply, write back)
// through the shared arithmetic, left before right.
// Reset loads the register defaults and clears the lowpass state; unwritten delay entries read as
// zero through the write index and a wrap flag, so no clearing pass is needed.
// The last right step holds while the previous result waits in the output register.
`default_nettype none
module stereo_feedback_delay (
  input wire logic  clk,
  input wire logic  rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch,
  sfd_cfg_if.sink   cfg_ch
);
  import sfd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LA   = 4'd1;
  localparam logic [3:0] ST_LB   = 4'd2;
  localparam logic [3:0] ST_LC   = 4'd3;
  localparam logic [3:0] ST_LD   = 4'd4;
  localparam logic [3:0] ST_RA   = 4'd5;
  localparam logic [3:0] ST_RB   = 4'd6;
  localparam logic [3:0] ST_RC   = 4'd7;
  localparam logic [3:0] ST_RD   = 4'd8;

  localparam logic [DL_W-1:0] DEPTH_D  = DL_W'(DELAY_DEPTH);
  localparam logic [DL_W-1:0] DEPTH_M1 = DL_W'(DELAY_DEPTH - 1);

  logic [3:0]  state_r, state_nxt;
  logic [15:0] delay_r;
  logic [14:0] gain_r;
  logic [15:0] wet_r;
  logic        pp_r;
  logic [14:0] damp_r;

  addr_t       wi_r;
  logic        wrap_r;
  logic        rvalid_r;
  logic        fwd_r;
  sample_t     dry_l_r, dry_r_r;
  logic        out_valid_r;
  sample_t     out_l_r, out_r_r;

  logic        in_fire;
  logic        out_free;
  logic        finish;
  logic [DL_W-1:0] dl_eff;
  logic [DL_W-1:0] wi_x;
  logic [DL_W-1:0] rd_x;
  addr_t       rd_addr;
  dp_ctrl_t    ctrl;
  store_req_t  req;
  sample_t     rdata_l, rdata_r;
  sample_t     wdata;
  sample_t     left_res, right_res;
  sample_t     dry;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_RD) && out_free;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;

  always_comb begin
    if ({{(DL_W-16){1'b0}}, delay_r} >= DEPTH_D) begin
      dl_eff = DEPTH_M1;
    end else begin
      dl_eff = {{(DL_W-16){1'b0}}, delay_r};
    end
    wi_x = DL_W'(wi_r);
    if (wi_x >= dl_eff) begin
      rd_x = wi_x - dl_eff;
    end else begin
      rd_x = wi_x + DEPTH_D - dl_eff;
    end
    rd_addr = rd_x[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LA;
      ST_LA:   state_nxt = ST_LB;
      ST_LB:   state_nxt = ST_LC;
      ST_LC:   state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_RA;
      ST_RA:   state_nxt = ST_RB;
      ST_RB:   state_nxt = ST_RC;
      ST_RC:   state_nxt = ST_RD;
      ST_RD:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.ch     = (state_r == ST_RA) || (state_r == ST_RB) ||
                  (state_r == ST_RC) || (state_r == ST_RD);
    ctrl.step_a = (state_r == ST_LA) || (state_r == ST_RA);
    ctrl.step_b = (state_r == ST_LB) || (state_r == ST_RB);
    ctrl.step_c = (state_r == ST_LC) || (state_r == ST_RC);
    ctrl.step_d = (state_r == ST_LD) || finish;
    dry         = ctrl.ch ? dry_r_r : dry_l_r;

    req.rd_en   = in_fire;
    req.rd_addr = rd_addr;
    req.we      = ctrl.step_d;
    req.wch     = ctrl.ch;
    req.waddr   = wi_r;
    req.wdata   = wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      delay_r     <= DELAY_RST;
      gain_r      <= GAIN_RST;
      wet_r       <= WET_RST;
      pp_r        <= 1'b0;
      damp_r      <= DAMP_RST;
      wi_r        <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DELAY: delay_r <= cfg_ch.data;
          REG_GAIN:  gain_r  <= (cfg_ch.data[14:0] > FB_LIMIT) ? FB_LIMIT : cfg_ch.data[14:0];
          REG_WET:   wet_r   <= (cfg_ch.data > WET_UNITY) ? WET_UNITY : cfg_ch.data;
          REG_PP:    pp_r    <= cfg_ch.data[0];
          REG_DAMP:  damp_r  <= cfg_ch.data[14:0];
          default: ;
        endcase
      end
      if (finish) begin
        if (DL_W'(wi_r) == DEPTH_M1) begin
          wi_r   <= '0;
          wrap_r <= 1'b1;
        end else begin
          wi_r <= wi_r + 1'b1;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dry_l_r  <= in_ch.left_sample;
      dry_r_r  <= in_ch.right_sample;
      rvalid_r <= wrap_r || (rd_addr < wi_r);
      fwd_r    <= (dl_eff == '0);
    end
    if (finish) begin
      out_l_r <= left_res;
      out_r_r <= right_res;
    end
  end

  sfd_store u_store (
    .clk     (clk),
    .req     (req),
    .rdata_l (rdata_l),
    .rdata_r (rdata_r)
  );

  sfd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .rdata_l   (rdata_l),
    .rdata_r   (rdata_r),
    .rvalid    (rvalid_r),
    .fwd       (fwd_r),
    .dry       (dry),
    .ping_pong (pp_r),
    .damp      (damp_r),
    .gain      (gain_r),
    .wet       (wet_r),
    .wdata     (wdata),
    .left_res  (left_res),
    .right_res (right_res)
  );

endmodule
`default_nettype wire

// File: rtl/core/sfd_store.sv
// Two-line delay memory: one read address for both lines, one write per cycle.
`default_nettype none
module sfd_store (
  input  wire logic                clk,
  input  wire sfd_pkg::store_req_t req,
  output sfd_pkg::sample_t         rdata_l,
  output sfd_pkg::sample_t         rdata_r
);
  import sfd_pkg::*;

  sample_t mem_l [DELAY_DEPTH];
  sample_t mem_r [DELAY_DEPTH];
  sample_t rdata_l_r;
  sample_t rdata_r_r;

  always_ff @(posedge clk) begin
    if (req.we && !req.wch) begin
      mem_l[req.waddr] <= req.wdata;
    end
    if (req.we && req.wch) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_l_r <= mem_l[req.rd_addr];
      rdata_r_r <= mem_r[req.rd_addr];
    end
  end

  assign rdata_l = rdata_l_r;
  assign rdata_r = rdata_r_r;

endmodule
`default_nettype wire

// File: rtl/core/sfd_dp.sv
// Per-channel arithmetic: lowpass update, feedback value and wet/dry mix.
`default_nettype none
module sfd_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfd_pkg::dp_ctrl_t ctrl,
  input  wire sfd_pkg::sample_t  rdata_l,
  input  wire sfd_pkg::sample_t  rdata_r,
  input  wire logic              rvalid,
  input  wire logic              fwd,
  input  wire sfd_pkg::sample_t  dry,
  input  wire logic              ping_pong,
  input  wire logic [14:0]       damp,
  input  wire logic [14:0]       gain,
  input  wire logic [15:0]       wet,
  output sfd_pkg::sample_t       wdata,
  output sfd_pkg::sample_t       left_res,
  output sfd_pkg::sample_t       right_res
);
  import sfd_pkg::*;

  function automatic sample_t sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  logic signed [LP_W-1:0] lp_r [2];
  logic signed [40:0]     p1_r;
  logic signed [33:0]     pw_r;
  logic signed [39:0]     p2_r;
  sample_t                res_r [2];
  sample_t                line_l_r;

  sample_t                d_sel;
  sample_t                d;
  logic signed [LP_W-1:0] lp_cur;
  logic signed [24:0]     diff;
  logic signed [16:0]     dd;
  logic signed [40:0]     p1_rnd;
  logic signed [26:0]     lp_sum;
  logic signed [LP_W-1:0] lp_clamp;
  logic signed [33:0]     pw_rnd;
  logic signed [39:0]     p2_rnd;

  always_comb begin
    if (ctrl.ch) begin
      d_sel = ping_pong ? rdata_l : rdata_r;
    end else begin
      d_sel = ping_pong ? rdata_r : rdata_l;
    end
    if (ctrl.ch && ping_pong && fwd) begin
      d = line_l_r;
    end else if (rvalid) begin
      d = d_sel;
    end else begin
      d = '0;
    end
    lp_cur = lp_r[ctrl.ch];
    diff   = 25'(signed'({d, 8'h00})) - 25'(lp_cur);
    dd     = 17'(d) - 17'(dry);

    p1_rnd = (p1_r + 41'sd16384) >>> 15;
    lp_sum = 27'(lp_cur) + 27'(p1_rnd);
    if (lp_sum > 27'sd8388607) begin
      lp_clamp = 24'sh7FFFFF;
    end else if (lp_sum < -27'sd8388608) begin
      lp_clamp = 24'sh800000;
    end else begin
      lp_clamp = lp_sum[LP_W-1:0];
    end
    pw_rnd = (pw_r + 34'sd16384) >>> 15;

    p2_rnd = (p2_r + 40'sd4194304) >>> 23;
    wdata  = sat16(21'(18'(dry) + 18'(p2_rnd)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r[0] <= '0;
      lp_r[1] <= '0;
    end else if (ctrl.step_b) begin
      lp_r[ctrl.ch] <= lp_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_a) begin
      p1_r <= 41'(diff) * 41'(signed'({1'b0, damp}));
      pw_r <= 34'(dd) * 34'(signed'({1'b0, wet}));
    end
    if (ctrl.step_b) begin
      res_r[ctrl.ch] <= sat16(21'(dry) + 21'(pw_rnd));
    end
    if (ctrl.step_c) begin
      p2_r <= 40'(lp_cur) * 40'(signed'({1'b0, gain}));
    end
    if (ctrl.step_d && !ctrl.ch) begin
      line_l_r <= wdata;
    end
  end

  assign left_res  = res_r[0];
  assign right_res = res_r[1];

endmodule
`default_nettype wire

// File: rtl/core/sfd_checker.sv
// Port-level checks of frame sequencing and result hold, bound to the top level.
`default_nettype none
module sfd_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire sfd_pkg::sample_t left_out,
  input wire sfd_pkg::sample_t right_out
);
  import sfd_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while a frame is in flight");

  a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##8 !in_ready)
    else $error("frame finished early");

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_fire, 9))
    else $error("result appeared without a frame accepted nine cycles before");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left_out  (out_ch.left_out),
  .right_out (out_ch.right_out)
);
`default_nettype wire
